// ===== rtl/conv3x3_clamp_edge_filter_top_macros.svh =====
// Assertion macros shared by the 3x3 edge filter RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef CONV3X3_CLAMP_EDGE_FILTER_TOP_MACROS_SVH
`define CONV3X3_CLAMP_EDGE_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CF3_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("cf3 check failed");
// Next-cycle implication, disabled while reset is asserted.
`define CF3_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("cf3 check failed");
`else
`define CF3_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons)
`define CF3_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== rtl/cf3_pkg.sv =====
// Shared types, constants and helpers of the 3x3 clamp-to-edge filter.
// No dependencies; used by the top level and the result queue.
package cf3_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_ABOVE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_BELOW   = 3'd4;

	localparam int CFG_DATA_W = 48;
	localparam int DIM_W      = 11;
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;
	localparam int COEF_W     = 48;
	localparam logic [COEF_W-1:0] COEF_CENTER_RESET = 48'h0000_4000_0000;

	// Operation codes carried in tuser.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int TAPS        = 3;
	localparam int TAP_W       = 16;
	localparam int PIX_W       = 8;
	localparam int PROD_W      = 25;
	localparam int SUM_W       = 28;
	localparam int FILT_W      = 22;
	localparam int OUT_TDATA_W = 24;
	localparam int ROUND_SHIFT = 6;
	localparam int ROUND_HALF  = 32;

	// Result queue depth, a power of two.
	localparam int FIFO_DEPTH = 16;

	typedef struct packed {
		logic                     last;
		logic signed [FILT_W-1:0] filtered;
	} cf3_result_t;

	// Up to two results enter the queue per cycle, A before B.
	typedef struct packed {
		logic        push_a;
		logic        push_b;
		cf3_result_t res_a;
		cf3_result_t res_b;
	} cf3_push_t;

	function automatic logic signed [TAP_W-1:0] tap_of(input logic [COEF_W-1:0] row,
			input int k);
		return $signed(row[TAP_W*k +: TAP_W]);
	endfunction

endpackage

// ===== rtl/cf3_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the line stores of the filter.
module cf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/cf3_out_fifo.sv =====
// Result queue of the filter: takes up to two results a cycle, gives one.
// Depends on cf3_pkg and the assertion macro header.
`include "conv3x3_clamp_edge_filter_top_macros.svh"
module cf3_out_fifo #(
	parameter int DEPTH = cf3_pkg::FIFO_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cf3_pkg::cf3_push_t       push,
	output logic [$clog2(DEPTH):0]   count,
	output logic                     out_valid,
	input  logic                     out_ready,
	output cf3_pkg::cf3_result_t     out_res
);

	localparam int AW = $clog2(DEPTH);

	cf3_pkg::cf3_result_t mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          pop;
	logic [AW-1:0] b_addr;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_res   = mem[rd_ptr_q];
	assign count     = count_q;
	assign b_addr    = push.push_a ? wr_ptr_q + 1'b1 : wr_ptr_q;

	always_ff @(posedge clk) begin
		if (push.push_a) begin
			mem[wr_ptr_q] <= push.res_a;
		end
		if (push.push_b) begin
			mem[b_addr] <= push.res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.push_a) + AW'(push.push_b);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(push.push_a) + (AW+1)'(push.push_b)
				- (AW+1)'(pop);
		end
	end

	// The upstream credit check must leave room for a pair of results.
	`CF3_ASSERT_IMPL(a_no_overflow, clk, arst_n, push.push_a || push.push_b, count_q <= (AW+1)'(DEPTH - 2))
	`CF3_ASSERT_IMPL(a_count_range, clk, arst_n, out_valid, count_q <= (AW+1)'(DEPTH))

endmodule

// ===== rtl/conv3x3_clamp_edge_filter_top.sv =====
// Top level of the 3x3 clamp-to-edge correlation filter.
// Depends on cf3_pkg, cf3_ram, cf3_out_fifo and the assertion macro header.
//
// Usage:
//   Pixels enter in raster order on the s_axis channel, one transfer per
//   clock at most. tuser carries the operation: a pixel item, or a drain
//   item that pushes the last row of a frame out once all its pixels are in.
//   Results leave on the m_axis channel as signed Q14.8 values; tlast marks
//   the result for the bottom-right pixel of a frame.
//   The result for pixel (x, y) is formed when the pixel at (x+1, y+1) is
//   taken, and the last column of a row also comes with the last pixel of
//   the next row; in rows over one pixel wide a row-end item gives two results.
//   A result passes through the line store read, the window and products,
//   the sum and rounding, and the result queue before it can be taken.
//   Throughput is one item per clock as long as the receiver keeps up and
//   the credit check of the result queue holds no item back.
//   When the receiver stalls, results collect in a 16-entry queue and
//   s_axis_tready drops once the queue cannot take the results of every
//   item still in the pipeline.
//   Reset restores the frame size (1024 x 1024) and the identity kernel and
//   clears counters and window, not the line stores (no clearing pass). The
//   user must write configuration while the block is idle; nothing enforces it.
`include "conv3x3_clamp_edge_filter_top_macros.svh"
module conv3x3_clamp_edge_filter_top #(
	parameter int MAX_WIDTH  = cf3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cf3_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [cf3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cf3_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input stream.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [cf3_pkg::PIX_W-1:0]           s_axis_tdata,  // [7:0] pixel
	input  logic [0:0]                          s_axis_tuser,  // [0] operation
	// Output stream.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [cf3_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [21:0] filtered
	output logic                                m_axis_tlast   // frame_last
);

	localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW  = $clog2(MAX_HEIGHT + 1);
	localparam int EWX = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (EWX > cf3_pkg::DIM_W) ? EWX : cf3_pkg::DIM_W;
	localparam int EHX = $clog2(MAX_HEIGHT + 1);
	localparam int EH  = (EHX > cf3_pkg::DIM_W) ? EHX : cf3_pkg::DIM_W;
	localparam int FAW = $clog2(cf3_pkg::FIFO_DEPTH);
	localparam int PW  = cf3_pkg::PIX_W;
	localparam int NT  = cf3_pkg::TAPS;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [cf3_pkg::DIM_W-1:0]  frame_width_q;
	logic [cf3_pkg::DIM_W-1:0]  frame_height_q;
	logic [cf3_pkg::COEF_W-1:0] coef_q [NT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= cf3_pkg::DIM_RESET;
			frame_height_q <= cf3_pkg::DIM_RESET;
			coef_q[0]      <= '0;
			coef_q[1]      <= cf3_pkg::COEF_CENTER_RESET;
			coef_q[2]      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cf3_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[cf3_pkg::DIM_W-1:0];
				cf3_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[cf3_pkg::DIM_W-1:0];
				cf3_pkg::CFG_COEF_ABOVE:   coef_q[0]      <= cfg_data[cf3_pkg::COEF_W-1:0];
				cf3_pkg::CFG_COEF_CENTER:  coef_q[1]      <= cfg_data[cf3_pkg::COEF_W-1:0];
				cf3_pkg::CFG_COEF_BELOW:   coef_q[2]      <= cfg_data[cf3_pkg::COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective frame size minus one: zero counts as one, oversize is capped.
	logic [EW-1:0] fw_ext;
	logic [EH-1:0] fh_ext;
	logic [XW-1:0] w_m1;
	logic [YW-1:0] h_m1;

	assign fw_ext = EW'(frame_width_q);
	assign fh_ext = EH'(frame_height_q);

	always_comb begin
		if (fw_ext == '0) begin
			w_m1 = '0;
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			w_m1 = XW'(MAX_WIDTH - 1);
		end else begin
			w_m1 = XW'(fw_ext - 1'b1);
		end
		if (fh_ext == '0) begin
			h_m1 = '0;
		end else if (fh_ext > EH'(MAX_HEIGHT)) begin
			h_m1 = YW'(MAX_HEIGHT - 1);
		end else begin
			h_m1 = YW'(fh_ext - 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// Accept stage: position counters and per-item control.
	// ------------------------------------------------------------------
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic [XW-1:0] c;
	logic          accept;
	logic          is_drain;
	logic          drain_phase;
	logic          active;
	logic          wr_lines;
	logic          c_last;
	logic          row_first;
	logic          has_a;
	logic          has_b;

	assign accept      = s_axis_tvalid && s_axis_tready;
	assign is_drain    = (s_axis_tuser[0] == cf3_pkg::OP_DRAIN);
	assign drain_phase = (row_q > h_m1);
	// A drain item that comes before the frame end does nothing at all.
	assign active      = !(is_drain && !drain_phase);
	assign wr_lines    = !is_drain && !drain_phase;
	assign c           = (col_q > w_m1) ? w_m1 : col_q;
	assign c_last      = (c == w_m1);
	assign row_first   = (row_q == '0);
	assign has_a       = active && !row_first && (c != '0);
	assign has_b       = active && !row_first && c_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && active) begin
			if (c_last) begin
				col_q <= '0;
				row_q <= drain_phase ? '0 : row_q + 1'b1;
			end else begin
				col_q <= c + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line store data arrives; window shift and products.
	// ------------------------------------------------------------------
	logic          v_s1;
	logic [XW-1:0] c_s1;
	logic [PW-1:0] px_s1;
	logic          wr_s1;
	logic          active_s1;
	logic          top_mid_s1;
	logic          bot_mid_s1;
	logic          has_a_s1;
	logic          has_b_s1;
	logic          fl_b_s1;
	logic          sel_a0_s1;
	logic          sel_b0_s1;
	logic          fwd_s1;
	logic [PW-1:0] fwd_px_q;
	logic [PW-1:0] fwd_mid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1       <= c;
			px_s1      <= s_axis_tdata;
			wr_s1      <= wr_lines;
			active_s1  <= active;
			top_mid_s1 <= (row_q <= YW'(1));
			bot_mid_s1 <= drain_phase;
			has_a_s1   <= has_a;
			has_b_s1   <= has_b;
			fl_b_s1    <= drain_phase;
			sel_a0_s1  <= (c == XW'(1));
			sel_b0_s1  <= (w_m1 == '0);
			// Back-to-back items at the same column (one-pixel rows) read
			// the line stores in the cycle the previous item writes them.
			fwd_s1     <= v_s1 && wr_s1 && (c_s1 == c);
		end
	end

	logic [PW-1:0] cur_rd;
	logic [PW-1:0] above_rd;
	logic [PW-1:0] mid;
	logic [PW-1:0] above;
	logic [PW-1:0] new_col [NT];

	assign mid        = fwd_s1 ? fwd_px_q  : cur_rd;
	assign above      = fwd_s1 ? fwd_mid_q : above_rd;
	assign new_col[0] = top_mid_s1 ? mid : above;
	assign new_col[1] = mid;
	assign new_col[2] = bot_mid_s1 ? mid : px_s1;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fwd_px_q  <= px_s1;
			fwd_mid_q <= mid;
		end
	end

	cf3_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_WIDTH)
	) u_line_above (
		.clk    (clk),
		.wr_en  (v_s1 && wr_s1),
		.wr_addr(c_s1),
		.wr_data(mid),
		.rd_en  (accept),
		.rd_addr(c),
		.rd_data(above_rd)
	);

	cf3_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_WIDTH)
	) u_line_current (
		.clk    (clk),
		.wr_en  (v_s1 && wr_s1),
		.wr_addr(c_s1),
		.wr_data(px_s1),
		.rd_en  (accept),
		.rd_addr(c),
		.rd_data(cur_rd)
	);

	// 3x3 window, rows above/center/below, columns oldest to newest.
	logic [PW-1:0] win_q [NT][NT];
	logic [PW-1:0] win_n [NT][NT];

	always_comb begin
		for (int i = 0; i < NT; i++) begin
			win_n[i][0] = win_q[i][1];
			win_n[i][1] = win_q[i][2];
			win_n[i][2] = new_col[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				for (int k = 0; k < NT; k++) begin
					win_q[i][k] <= '0;
				end
			end
		end else if (v_s1 && active_s1) begin
			win_q <= win_n;
		end
	end

	// Result A is column c-1 (its left neighbor clamps at column zero);
	// result B is the last column, its right neighbor clamped.
	logic signed [cf3_pkg::PROD_W-1:0] prod_a [NT][NT];
	logic signed [cf3_pkg::PROD_W-1:0] prod_b [NT][NT];
	logic [PW-1:0] pa [NT][NT];
	logic [PW-1:0] pb [NT][NT];

	always_comb begin
		for (int i = 0; i < NT; i++) begin
			pa[i][0] = sel_a0_s1 ? win_n[i][1] : win_n[i][0];
			pa[i][1] = win_n[i][1];
			pa[i][2] = win_n[i][2];
			pb[i][0] = sel_b0_s1 ? win_n[i][2] : win_n[i][1];
			pb[i][1] = win_n[i][2];
			pb[i][2] = win_n[i][2];
			for (int k = 0; k < NT; k++) begin
				prod_a[i][k] = cf3_pkg::tap_of(coef_q[i], k) * $signed({1'b0, pa[i][k]});
				prod_b[i][k] = cf3_pkg::tap_of(coef_q[i], k) * $signed({1'b0, pb[i][k]});
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: registered products; sums and rounding.
	// ------------------------------------------------------------------
	logic v_s2;
	logic has_a_s2;
	logic has_b_s2;
	logic fl_b_s2;
	logic signed [cf3_pkg::PROD_W-1:0] prod_a_s2 [NT][NT];
	logic signed [cf3_pkg::PROD_W-1:0] prod_b_s2 [NT][NT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			has_a_s2  <= has_a_s1;
			has_b_s2  <= has_b_s1;
			fl_b_s2   <= fl_b_s1;
			prod_a_s2 <= prod_a;
			prod_b_s2 <= prod_b;
		end
	end

	// Q2.14 times integer pixels gives 14 fraction bits; round half up to 8.
	function automatic logic signed [cf3_pkg::FILT_W-1:0] round_q8(
			input logic signed [cf3_pkg::SUM_W-1:0] s);
		logic signed [cf3_pkg::SUM_W-1:0] t;
		t = (s + cf3_pkg::SUM_W'(cf3_pkg::ROUND_HALF)) >>> cf3_pkg::ROUND_SHIFT;
		return t[cf3_pkg::FILT_W-1:0];
	endfunction

	logic signed [cf3_pkg::SUM_W-1:0] sum_a;
	logic signed [cf3_pkg::SUM_W-1:0] sum_b;

	always_comb begin
		sum_a = '0;
		sum_b = '0;
		for (int i = 0; i < NT; i++) begin
			for (int k = 0; k < NT; k++) begin
				sum_a = sum_a + cf3_pkg::SUM_W'(prod_a_s2[i][k]);
				sum_b = sum_b + cf3_pkg::SUM_W'(prod_b_s2[i][k]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: finished results, pushed into the queue.
	// ------------------------------------------------------------------
	logic                 v_s3;
	logic                 has_a_s3;
	logic                 has_b_s3;
	cf3_pkg::cf3_result_t res_a_s3;
	cf3_pkg::cf3_result_t res_b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			has_a_s3          <= has_a_s2;
			has_b_s3          <= has_b_s2;
			// Result A is never the last column, so it never closes a frame.
			res_a_s3.last     <= 1'b0;
			res_a_s3.filtered <= round_q8(sum_a);
			res_b_s3.last     <= fl_b_s2;
			res_b_s3.filtered <= round_q8(sum_b);
		end
	end

	cf3_pkg::cf3_push_t   push;
	cf3_pkg::cf3_result_t out_res;
	logic [FAW:0]         fifo_count;

	assign push.push_a = v_s3 && has_a_s3;
	assign push.push_b = v_s3 && has_b_s3;
	assign push.res_a  = res_a_s3;
	assign push.res_b  = res_b_s3;

	cf3_out_fifo #(
		.DEPTH(cf3_pkg::FIFO_DEPTH)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.count    (fifo_count),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = {{(cf3_pkg::OUT_TDATA_W - cf3_pkg::FILT_W){1'b0}},
		out_res.filtered};
	assign m_axis_tlast = out_res.last;

	// Credit: every item in flight and the new one may each add two results.
	logic [FAW+1:0] inflight_x2;
	logic [FAW+1:0] pending;

	assign inflight_x2 = ((FAW+2)'(v_s1) + (FAW+2)'(v_s2) + (FAW+2)'(v_s3)) << 1;
	assign pending     = (FAW+2)'(fifo_count) + inflight_x2;
	assign s_axis_tready = (pending <= (FAW+2)'(cf3_pkg::FIFO_DEPTH - 2));

	`CF3_ASSERT_IMPL(a_credit_room, clk, arst_n, s_axis_tready, fifo_count <= (FAW+1)'(cf3_pkg::FIFO_DEPTH - 2))
	`CF3_ASSERT_NEXT(a_ignored_holds, clk, arst_n, accept && !active, $stable(col_q) && $stable(row_q))
	`CF3_ASSERT_NEXT(a_drain_wrap, clk, arst_n, accept && active && drain_phase && c_last, (row_q == '0) && (col_q == '0))

endmodule
